[rtl/glm_pkg.sv]
// Shared constants, types and state codes of the gain and level meter.
package glm_pkg;

   localparam int SAMPLE_BITS       = 24;
   localparam int MAX_BLOCK_SAMPLES = 16384;
   localparam int COUNT_BITS        = $clog2(MAX_BLOCK_SAMPLES + 1);
   localparam int SUM_BITS          = 38;
   localparam int LEVEL_BITS        = 16;
   localparam int GAIN_BITS         = 17;
   localparam int COEF_BITS         = 16;
   localparam int FRAC_BITS         = 16;
   localparam int MEAN_SHIFT        = SAMPLE_BITS - 1 - LEVEL_BITS;
   localparam int DIVIDEND_BITS     = SUM_BITS - MEAN_SHIFT;
   localparam int DIV_HI_BITS       = DIVIDEND_BITS - LEVEL_BITS;
   localparam int STEP_BITS         = $clog2(LEVEL_BITS);
   localparam int PROD_BITS         = SAMPLE_BITS + GAIN_BITS;
   localparam int MAG_BITS          = PROD_BITS + 1 - FRAC_BITS;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int CSR_DATA_BITS     = GAIN_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE = 2'd2;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(32768);
   localparam logic [PROD_BITS:0]   ROUND_HALF = (PROD_BITS + 1)'(1) << (FRAC_BITS - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_SAT,
      S_DIVI,
      S_WAITI,
      S_SMI_MUL,
      S_SMI_UPD,
      S_DIVO,
      S_WAITO,
      S_SMO_MUL,
      S_SMO_UPD,
      S_PUSH
   } state_type;

   typedef struct packed {
      logic                     start;
      logic [DIVIDEND_BITS-1:0] dividend;
      logic [COUNT_BITS-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [LEVEL_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/gain_and_level_meter.sv]
// Top level: sample gain with saturation and block mean-level meters with smoothing.
//
//  Channel | Direction | Handshake                 | Payload
//  req     | in        | req_valid / req_stall     | sample_in, block_end
//  rsp     | out       | rsp_valid / rsp_stall     | sample_out, input/output_level, updated
//  csr     | in        | csr_valid / csr_ready     | csr_index, csr_data
//
// An ordinary sample passes through the multiply, saturate and push states to the
// result register.
// A block-ending sample also takes the input mean on the shared divider, smooths the
// input meter, then does the same for the output mean and meter before the push.
// The block takes one sample at a time; a finished result may wait in the output register.
// Reset restores the register defaults and clears the sums, the count and both meters.
// A stalled result holds while the next sample is already processed.
module gain_and_level_meter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [glm_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  logic                                  req_block_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [glm_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   output logic [glm_pkg::LEVEL_BITS-1:0]         rsp_input_level,
   output logic [glm_pkg::LEVEL_BITS-1:0]         rsp_output_level,
   output logic                                  rsp_levels_updated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [glm_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [glm_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   localparam int SB = glm_pkg::SAMPLE_BITS;
   localparam int LB = glm_pkg::LEVEL_BITS;

   glm_pkg::state_type state_ff, state_in;

   logic [glm_pkg::GAIN_BITS-1:0]  gain_ff;
   logic [glm_pkg::COEF_BITS-1:0]  attack_ff;
   logic [glm_pkg::COEF_BITS-1:0]  release_ff;
   logic [glm_pkg::SUM_BITS-1:0]   in_sum_ff;
   logic [glm_pkg::SUM_BITS-1:0]   out_sum_ff;
   logic [glm_pkg::COUNT_BITS-1:0] count_ff;
   logic [LB-1:0]                  in_meter_ff;
   logic [LB-1:0]                  out_meter_ff;

   logic [SB-1:0]                  ax_ff;
   logic                           neg_ff;
   logic                           end_ff;
   logic [glm_pkg::PROD_BITS-1:0]  prod_ff;
   logic                           rise_ff;
   logic [SB-1:0]                  ybits_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]                  rsp_sample_ff;
   logic [LB-1:0]                  rsp_in_level_ff;
   logic [LB-1:0]                  rsp_out_level_ff;
   logic                           rsp_updated_ff;

   logic                           accept;
   logic                           push;
   logic                           sel_out;
   logic                           smooth_mul;
   logic [SB-1:0]                  mul_a;
   logic [glm_pkg::GAIN_BITS-1:0]  mul_b;
   logic [glm_pkg::PROD_BITS-1:0]  mul_p;
   logic [LB-1:0]                  level;
   logic [LB-1:0]                  target;
   logic                           rise;
   logic [LB-1:0]                  level_diff;
   logic [glm_pkg::COEF_BITS-1:0]  coef;
   logic [2*LB:0]                  step_sum;
   logic [LB-1:0]                  step;
   logic [glm_pkg::PROD_BITS:0]    rounded;
   logic [glm_pkg::MAG_BITS-1:0]   mag;
   logic [SB-1:0]                  limit;
   logic [SB-1:0]                  yabs;
   logic [SB-1:0]                  sample_bits;
   logic                           room;

   glm_pkg::div_req_type div_req;
   glm_pkg::div_rsp_type div_rsp;

   glm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = state_ff != glm_pkg::S_IDLE;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign push      = (state_ff == glm_pkg::S_PUSH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         glm_pkg::S_IDLE:    if (accept) state_in = glm_pkg::S_MUL;
         glm_pkg::S_MUL:     state_in = glm_pkg::S_SAT;
         glm_pkg::S_SAT:     state_in = end_ff ? glm_pkg::S_DIVI : glm_pkg::S_PUSH;
         glm_pkg::S_DIVI:    state_in = glm_pkg::S_WAITI;
         glm_pkg::S_WAITI:   if (div_rsp.done) state_in = glm_pkg::S_SMI_MUL;
         glm_pkg::S_SMI_MUL: state_in = glm_pkg::S_SMI_UPD;
         glm_pkg::S_SMI_UPD: state_in = glm_pkg::S_DIVO;
         glm_pkg::S_DIVO:    state_in = glm_pkg::S_WAITO;
         glm_pkg::S_WAITO:   if (div_rsp.done) state_in = glm_pkg::S_SMO_MUL;
         glm_pkg::S_SMO_MUL: state_in = glm_pkg::S_SMO_UPD;
         glm_pkg::S_SMO_UPD: state_in = glm_pkg::S_PUSH;
         glm_pkg::S_PUSH:    if (push) state_in = glm_pkg::S_IDLE;
         default:            state_in = glm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      div_req    = '0;
      sel_out    = 1'b0;
      smooth_mul = 1'b0;
      unique case (state_ff)
         glm_pkg::S_DIVI: begin
            div_req.start    = 1'b1;
            div_req.dividend = in_sum_ff[glm_pkg::SUM_BITS-1:glm_pkg::MEAN_SHIFT];
            div_req.divisor  = count_ff;
         end
         glm_pkg::S_DIVO: begin
            div_req.start    = 1'b1;
            div_req.dividend = out_sum_ff[glm_pkg::SUM_BITS-1:glm_pkg::MEAN_SHIFT];
            div_req.divisor  = count_ff;
         end
         glm_pkg::S_SMI_MUL: smooth_mul = 1'b1;
         glm_pkg::S_SMO_MUL: begin
            smooth_mul = 1'b1;
            sel_out    = 1'b1;
         end
         glm_pkg::S_SMO_UPD: sel_out = 1'b1;
         default: ;
      endcase
   end

   // Shared multiplier: gain product for the sample, coefficient product for smoothing.
   assign level      = sel_out ? out_meter_ff : in_meter_ff;
   assign target     = div_rsp.quotient;
   assign rise       = target > level;
   assign level_diff = rise ? target - level : level - target;
   assign coef       = rise ? attack_ff : release_ff;
   assign mul_a      = smooth_mul ? SB'(level_diff) : ax_ff;
   assign mul_b      = smooth_mul ? glm_pkg::GAIN_BITS'(coef) : gain_ff;
   assign mul_p      = glm_pkg::PROD_BITS'(mul_a) * glm_pkg::PROD_BITS'(mul_b);

   assign step_sum = (2*LB+1)'(prod_ff[2*LB-1:0]) + ((2*LB+1)'(1) << (LB - 1));
   assign step     = step_sum[2*LB-1:LB];

   assign rounded     = {1'b0, prod_ff} + glm_pkg::ROUND_HALF;
   assign mag         = rounded[glm_pkg::PROD_BITS:glm_pkg::FRAC_BITS];
   assign limit       = neg_ff ? (SB'(1) << (SB - 1)) : ((SB'(1) << (SB - 1)) - SB'(1));
   assign yabs        = (mag > glm_pkg::MAG_BITS'(limit)) ? limit : mag[SB-1:0];
   assign sample_bits = req_sample_in;
   assign room        = count_ff < glm_pkg::COUNT_BITS'(glm_pkg::MAX_BLOCK_SAMPLES);

   assign rsp_valid_in = push ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= glm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= glm_pkg::GAIN_RESET;
         attack_ff    <= '0;
         release_ff   <= '0;
         in_sum_ff    <= '0;
         out_sum_ff   <= '0;
         count_ff     <= '0;
         in_meter_ff  <= '0;
         out_meter_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               glm_pkg::CSR_GAIN:    gain_ff    <= csr_data;
               glm_pkg::CSR_ATTACK:  attack_ff  <= csr_data[glm_pkg::COEF_BITS-1:0];
               glm_pkg::CSR_RELEASE: release_ff <= csr_data[glm_pkg::COEF_BITS-1:0];
               default: ;
            endcase
         end
         if (state_ff == glm_pkg::S_SAT && room) begin
            in_sum_ff  <= in_sum_ff + glm_pkg::SUM_BITS'(ax_ff);
            out_sum_ff <= out_sum_ff + glm_pkg::SUM_BITS'(yabs);
            count_ff   <= count_ff + 1'b1;
         end
         if (state_ff == glm_pkg::S_SMI_UPD) begin
            in_meter_ff <= rise_ff ? in_meter_ff + step : in_meter_ff - step;
         end
         if (state_ff == glm_pkg::S_SMO_UPD) begin
            out_meter_ff <= rise_ff ? out_meter_ff + step : out_meter_ff - step;
            in_sum_ff    <= '0;
            out_sum_ff   <= '0;
            count_ff     <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff <= sample_bits[SB-1];
         ax_ff  <= sample_bits[SB-1] ? SB'(~sample_bits + SB'(1)) : sample_bits;
         end_ff <= req_block_end;
      end
      if (state_ff == glm_pkg::S_MUL || smooth_mul) begin
         prod_ff <= mul_p;
      end
      if (smooth_mul) begin
         rise_ff <= rise;
      end
      if (state_ff == glm_pkg::S_SAT) begin
         ybits_ff <= neg_ff ? SB'(~yabs + SB'(1)) : yabs;
      end
      if (push) begin
         rsp_sample_ff    <= ybits_ff;
         rsp_in_level_ff  <= in_meter_ff;
         rsp_out_level_ff <= out_meter_ff;
         rsp_updated_ff   <= end_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_out     = rsp_sample_ff;
   assign rsp_input_level    = rsp_in_level_ff;
   assign rsp_output_level   = rsp_out_level_ff;
   assign rsp_levels_updated = rsp_updated_ff;

endmodule

[rtl/glm_div.sv]
// Radix-2 restoring divider that forms a clamped 16-bit mean level, one bit per cycle.
module glm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  glm_pkg::div_req_type div_req,
   output glm_pkg::div_rsp_type div_rsp
);

   localparam int CMP_BITS = (glm_pkg::DIV_HI_BITS > glm_pkg::COUNT_BITS) ?
                             glm_pkg::DIV_HI_BITS : glm_pkg::COUNT_BITS;

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic                             over_ff, over_in;
   logic [glm_pkg::STEP_BITS-1:0]    cnt_ff, cnt_in;
   logic [glm_pkg::COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [glm_pkg::LEVEL_BITS-1:0]   quo_ff, quo_in;
   logic [glm_pkg::COUNT_BITS-1:0]   div_ff, div_in;
   logic [glm_pkg::DIV_HI_BITS-1:0]  hi;
   logic [glm_pkg::COUNT_BITS:0]     trial;
   logic [glm_pkg::COUNT_BITS:0]     diff;
   logic                             ge;

   assign hi    = div_req.dividend[glm_pkg::DIVIDEND_BITS-1:glm_pkg::LEVEL_BITS];
   assign trial = {rem_ff, quo_ff[glm_pkg::LEVEL_BITS-1]};
   assign ge    = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      over_in = over_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         over_in = CMP_BITS'(hi) >= CMP_BITS'(div_req.divisor);
         cnt_in  = '0;
         rem_in  = glm_pkg::COUNT_BITS'(hi);
         quo_in  = div_req.dividend[glm_pkg::LEVEL_BITS-1:0];
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[glm_pkg::COUNT_BITS-1:0] : trial[glm_pkg::COUNT_BITS-1:0];
         quo_in = {quo_ff[glm_pkg::LEVEL_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == glm_pkg::STEP_BITS'(glm_pkg::LEVEL_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      over_ff <= over_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = over_ff ? '1 : quo_ff;

endmodule

[rtl/glm_checker.sv]
// Port-level checks of the gain and level meter, bound to the top level.
module glm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic signed [glm_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input logic                                  req_block_end,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [glm_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input logic [glm_pkg::LEVEL_BITS-1:0]         rsp_input_level,
   input logic [glm_pkg::LEVEL_BITS-1:0]         rsp_output_level,
   input logic                                  rsp_levels_updated,
   input logic                                  csr_valid,
   input logic                                  csr_ready
);

   // No result is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // After a sample transfer the block is busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took a new sample without processing time");

   // A stalled result holds its whole payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_input_level) && $stable(rsp_output_level)
         && $stable(rsp_levels_updated)))
      else $error("stalled result changed");

   // A stalled sample holds its whole payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_sample_in)
         && $stable(req_block_end)))
      else $error("stalled sample changed");

   // The configuration port never refuses a write.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration port refused a write");

endmodule

bind gain_and_level_meter glm_checker u_glm_checker (.*);
